// ----- design/llt_pkg.sv -----
// ----------------------------------------------------------------------------
// llt_pkg: shared types and constants for the lambda language tokenizer
// Payload layouts, token kinds, lexer modes and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none

package llt_pkg;

  typedef logic [5:0] kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    logic [30:0] number_value;
    logic        lex_error;
    logic        last_result;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_NUM   = 3'd1,
    MODE_WORD  = 3'd2,
    MODE_MINUS = 3'd3,
    MODE_ERR   = 3'd4
  } lex_mode_t;

  localparam kind_t KIND_ID     = 6'd0;
  localparam kind_t KIND_NUM    = 6'd1;
  localparam kind_t KIND_ARROW  = 6'd2;
  localparam kind_t KIND_PUNCT0 = 6'd3;
  localparam kind_t KIND_KW0    = 6'd15;
  localparam kind_t KIND_END    = 6'd39;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
  localparam logic [7:0] CH_USCORE = 8'h5F;  // '_'
  localparam logic [7:0] CH_QUOTE  = 8'h27;  // '\''

  localparam int NUM_PUNCT = 12;
  localparam logic [7:0] PUNCT_CHARS [NUM_PUNCT] = '{
    8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3D, 8'h5F,   // . , : ; = _
    8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D    // ( ) { } [ ]
  };

  // Keyword text, left-justified, first character in the top byte.
  localparam int NUM_KW     = 24;
  localparam int KW_MAX_LEN = 6;
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    {"if", 48'h0}, {"then", 32'h0}, {"else", 32'h0}, {"true", 32'h0},
    {"false", 24'h0}, {"pred", 32'h0}, {"succ", 32'h0}, {"iszero", 16'h0},
    {"nil", 40'h0}, {"cons", 32'h0}, {"isnil", 24'h0}, {"head", 32'h0},
    {"tail", 32'h0}, {"unit", 32'h0}, {"lambda", 16'h0}, {"let", 40'h0},
    {"in", 48'h0}, {"letrec", 16'h0}, {"type", 32'h0}, {"as", 48'h0},
    {"Bool", 32'h0}, {"Nat", 40'h0}, {"List", 32'h0}, {"Unit", 32'h0}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd6,
    3'd3, 3'd4, 3'd5, 3'd4, 3'd4, 3'd4, 3'd6, 3'd3,
    3'd2, 3'd6, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd4
  };

endpackage

`default_nettype wire

// ----- design/llt_chan_if.sv -----
// ----------------------------------------------------------------------------
// llt_chan_if: valid/ready channel
// Carries one payload beat per handshake; payload type set per instance.
// ----------------------------------------------------------------------------
`default_nettype none

interface llt_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- design/lambda_language_tokenizer.sv -----
// ----------------------------------------------------------------------------
// lambda_language_tokenizer: streaming lexer for a small lambda language
// One character per beat in, zero to three token beats out per character.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload                                   | notes
//   ----------+-----+-------------------------------------------+----------------
//   in_chan   | in  | ch[8], final_char                         | one char a beat
//   out_chan  | out | kind[6], start_pos[16], end_pos[16],      | one token a beat
//             |     | number_value[31], lex_error, last_result  |
//
// Flow: a character waits in the input register while the lexer step runs
//   and loads its tokens into the result buffer. A character giving at most
//   one token passes at one per cycle while out_chan is ready; one giving
//   more holds the next until its tokens have left the single output port.
// Reset: synchronous, active low; the lexer returns to idle at offset zero
//   and the result buffer empties.
// Stalls: the input register is taken again in the cycle it is consumed;
//   it is consumed only once the result buffer drains (or its last beat
//   leaves in the same cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module lambda_language_tokenizer #(
  parameter int MAX_TEXT_LENGTH = 65536,
  parameter int KEYWORD_CHARS   = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  llt_chan_if.sink   in_chan,
  llt_chan_if.source out_chan
);

  localparam int PW = $clog2(MAX_TEXT_LENGTH);
  localparam int LW = $clog2(KEYWORD_CHARS + 2);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // advance an offset, wrapping at the text length limit
  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    return (p == PW'(MAX_TEXT_LENGTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // report the low 16 bits of an offset
  function automatic logic [15:0] to16(input logic [PW-1:0] p);
    logic [PW+15:0] t;
    t = {16'b0, p};
    return t[15:0];
  endfunction

  function automatic llt_pkg::out_item_t mk(input llt_pkg::kind_t k,
                                            input logic [PW-1:0] s,
                                            input logic [PW-1:0] e,
                                            input logic [30:0] v,
                                            input logic err,
                                            input logic last);
    llt_pkg::out_item_t r;
    r.kind         = k;
    r.start_pos    = to16(s);
    r.end_pos      = to16(e);
    r.number_value = v;
    r.lex_error    = err;
    r.last_result  = last;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               hold_r;
  llt_pkg::in_item_t  in_q_r;
  logic               can_load;
  logic               proc;
  logic               in_fire;

  logic [1:0]         cnt_r;
  llt_pkg::out_item_t slot_r [3];
  logic               pop;

  assign pop      = (cnt_r != 2'd0) && out_chan.ready;
  assign can_load = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_chan.ready);
  assign proc     = hold_r && can_load;
  assign in_chan.ready = !hold_r || proc;
  assign in_fire  = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else if (in_fire) begin
      hold_r <= 1'b1;
    end else if (proc) begin
      hold_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_q_r <= in_chan.data;
    end
  end

  // --------------------------------------------------------------------------
  // Lexer state
  // --------------------------------------------------------------------------
  llt_pkg::lex_mode_t mode_r, mode_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [PW-1:0]      ts_r, ts_nxt;
  logic [30:0]        acc_r, acc_nxt;
  logic [LW-1:0]      len_r, len_nxt;
  logic [KEYWORD_CHARS-1:0][7:0] buf_r;
  logic [KEYWORD_CHARS-1:0][7:0] buf_eff;
  logic [LW-1:0]      len_eff;

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  logic [7:0]     ch;
  logic           fin;
  logic           is_dig, is_alp, is_blk, is_idc, is_pun;
  llt_pkg::kind_t pkind;

  assign ch  = in_q_r.ch;
  assign fin = in_q_r.final_char;

  always_comb begin
    is_dig = ch inside {[8'h30:8'h39]};
    is_alp = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    is_blk = ch inside {8'h20, 8'h09, 8'h0D, 8'h0A};
    is_idc = is_dig || is_alp || ch == llt_pkg::CH_USCORE || ch == llt_pkg::CH_QUOTE;
    is_pun = 1'b0;
    pkind  = llt_pkg::KIND_PUNCT0;
    for (int p = 0; p < llt_pkg::NUM_PUNCT; p++) begin
      if (ch == llt_pkg::PUNCT_CHARS[p]) begin
        is_pun = 1'b1;
        pkind  = llt_pkg::KIND_PUNCT0 + 6'(p);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Word buffer view after this character: a word either grows by one or
  // a fresh word starts; a word is never flushed and restarted in one step.
  // --------------------------------------------------------------------------
  logic word_wr;
  logic word_start;

  assign word_wr    = (mode_r == llt_pkg::MODE_WORD) && is_idc;
  assign word_start = is_alp && (mode_r == llt_pkg::MODE_IDLE ||
                                 mode_r == llt_pkg::MODE_NUM);

  always_comb begin
    buf_eff = buf_r;
    len_eff = len_r;
    if (word_start) begin
      buf_eff[0] = ch;
      len_eff    = LW'(1);
    end else if (word_wr) begin
      for (int i = 0; i < KEYWORD_CHARS; i++) begin
        if (len_r == LW'(i)) begin
          buf_eff[i] = ch;
        end
      end
      if (len_r <= LW'(KEYWORD_CHARS)) begin
        len_eff = len_r + 1'b1;
      end
    end
  end

  llt_pkg::kind_t word_kind;

  llt_keyword_match #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_kw (
    .word_buf  (buf_eff),
    .word_len  (len_eff),
    .word_kind (word_kind)
  );

  // --------------------------------------------------------------------------
  // Lexer step: next state and up to three tokens
  // --------------------------------------------------------------------------
  logic [PW-1:0]      nxt;
  logic [34:0]        acc_sum;
  logic               consumed;
  logic               stop;
  logic [1:0]         n_res;
  llt_pkg::out_item_t res [3];

  assign nxt     = pos_inc(pos_r);
  assign acc_sum = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 35'(ch[3:0]);

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = nxt;
    ts_nxt   = ts_r;
    acc_nxt  = acc_r;
    len_nxt  = len_eff;
    consumed = 1'b0;
    stop     = 1'b0;
    n_res    = 2'd0;
    for (int j = 0; j < 3; j++) begin
      res[j] = '0;
    end

    case (mode_r)
      llt_pkg::MODE_ERR: begin
        stop = 1'b1;
      end
      llt_pkg::MODE_MINUS: begin
        if (ch == llt_pkg::CH_GT) begin
          res[n_res] = mk(llt_pkg::KIND_ARROW, ts_r, nxt, '0, 1'b0, 1'b0);
          n_res      = n_res + 2'd1;
          mode_nxt   = llt_pkg::MODE_IDLE;
          consumed   = 1'b1;
        end else begin
          // lone minus: report at the '-', drop this character
          res[n_res] = mk(llt_pkg::KIND_END, ts_r, pos_inc(ts_r), '0, 1'b1, 1'b1);
          n_res      = n_res + 2'd1;
          mode_nxt   = llt_pkg::MODE_ERR;
          stop       = 1'b1;
        end
      end
      llt_pkg::MODE_NUM: begin
        if (is_dig) begin
          acc_nxt  = (acc_sum > 35'(llt_pkg::NUM_MAX)) ? llt_pkg::NUM_MAX : acc_sum[30:0];
          consumed = 1'b1;
        end else begin
          res[n_res] = mk(llt_pkg::KIND_NUM, ts_r, pos_r, acc_r, 1'b0, 1'b0);
          n_res      = n_res + 2'd1;
          mode_nxt   = llt_pkg::MODE_IDLE;
        end
      end
      llt_pkg::MODE_WORD: begin
        if (is_idc) begin
          consumed = 1'b1;
        end else begin
          res[n_res] = mk(word_kind, ts_r, pos_r, '0, 1'b0, 1'b0);
          n_res      = n_res + 2'd1;
          mode_nxt   = llt_pkg::MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    // start a new token with this character
    if (!consumed && !stop) begin
      if (is_blk) begin
      end else if (is_pun) begin
        res[n_res] = mk(pkind, pos_r, nxt, '0, 1'b0, 1'b0);
        n_res      = n_res + 2'd1;
      end else if (ch == llt_pkg::CH_MINUS) begin
        mode_nxt = llt_pkg::MODE_MINUS;
        ts_nxt   = pos_r;
      end else if (is_dig) begin
        mode_nxt = llt_pkg::MODE_NUM;
        ts_nxt   = pos_r;
        acc_nxt  = 31'(ch[3:0]);
      end else if (is_alp) begin
        mode_nxt = llt_pkg::MODE_WORD;
        ts_nxt   = pos_r;
      end else begin
        res[n_res] = mk(llt_pkg::KIND_END, pos_r, nxt, '0, 1'b1, 1'b1);
        n_res      = n_res + 2'd1;
        mode_nxt   = llt_pkg::MODE_ERR;
        stop       = 1'b1;
      end
    end

    // close the text: flush the pending token, then the end marker; a pending minus gives the lone-minus error instead
    if (!stop && fin) begin
      if (mode_nxt == llt_pkg::MODE_MINUS) begin
        res[n_res] = mk(llt_pkg::KIND_END, ts_nxt, pos_inc(ts_nxt), '0, 1'b1, 1'b1);
        n_res      = n_res + 2'd1;
      end else begin
        if (mode_nxt == llt_pkg::MODE_NUM) begin
          res[n_res] = mk(llt_pkg::KIND_NUM, ts_nxt, nxt, acc_nxt, 1'b0, 1'b0);
          n_res      = n_res + 2'd1;
        end else if (mode_nxt == llt_pkg::MODE_WORD) begin
          res[n_res] = mk(word_kind, ts_nxt, nxt, '0, 1'b0, 1'b0);
          n_res      = n_res + 2'd1;
        end
        res[n_res] = mk(llt_pkg::KIND_END, nxt, nxt, '0, 1'b0, 1'b1);
        n_res      = n_res + 2'd1;
      end
    end

    // the last flag always restarts offsets for the next text
    if (fin) begin
      mode_nxt = llt_pkg::MODE_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      acc_nxt  = '0;
      len_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= llt_pkg::MODE_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      acc_r  <= '0;
      len_r  <= '0;
    end else if (proc) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      acc_r  <= acc_nxt;
      len_r  <= len_nxt;
    end
  end

  // word buffer entries, only read below the word length
  always_ff @(posedge clk) begin
    if (proc) begin
      buf_r <= buf_eff;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: slot 0 faces the port, later slots shift down on a beat
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (proc) begin
      cnt_r <= n_res;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      slot_r[0] <= res[0];
      slot_r[1] <= res[1];
      slot_r[2] <= res[2];
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

  assign out_chan.valid = (cnt_r != 2'd0);
  assign out_chan.data  = slot_r[0];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_load_only_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    proc |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_chan.ready)))
    else $error("result buffer reloaded while beats still pending");

  a_error_beat_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.data.lex_error) |->
      (out_chan.data.last_result && out_chan.data.kind == llt_pkg::KIND_END))
    else $error("error beat without end kind or last flag");

  a_error_mode_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (proc && mode_r == llt_pkg::MODE_ERR) |-> (n_res == 2'd0))
    else $error("tokens produced after a lexical error");

  a_last_char_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (proc && fin && mode_r != llt_pkg::MODE_ERR) |=> (cnt_r != 2'd0))
    else $error("last character produced no closing beat");

endmodule

`default_nettype wire

// ----- design/llt_keyword_match.sv -----
// ----------------------------------------------------------------------------
// llt_keyword_match: keyword lookup for the word buffer
// Compares the buffered word against all keywords in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module llt_keyword_match #(
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic [KEYWORD_CHARS-1:0][7:0]             word_buf,
  input  wire logic [$clog2(KEYWORD_CHARS+2)-1:0]        word_len,
  output llt_pkg::kind_t                                 word_kind
);

  localparam int LW = $clog2(KEYWORD_CHARS + 2);

  logic [llt_pkg::NUM_KW-1:0] hit;

  always_comb begin
    for (int k = 0; k < llt_pkg::NUM_KW; k++) begin
      hit[k] = (word_len == LW'(llt_pkg::KW_LEN[k]));
      for (int i = 0; i < llt_pkg::KW_MAX_LEN; i++) begin
        if (i < int'(llt_pkg::KW_LEN[k]) &&
            word_buf[i] != llt_pkg::KW_TEXT[k][63-8*i -: 8]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  // lowest keyword index wins
  always_comb begin
    word_kind = llt_pkg::KIND_ID;
    for (int k = llt_pkg::NUM_KW - 1; k >= 0; k--) begin
      if (hit[k]) begin
        word_kind = llt_pkg::KIND_KW0 + 6'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/lambda_language_tokenizer_test.sv -----
// ----------------------------------------------------------------------------
// lambda_language_tokenizer_test: self-checking bench for the token lexer
// Streams character beats into the lexer, forecasts each token beat with an
// in-bench lexer and compares every token beat field by field, in order.
// ----------------------------------------------------------------------------
module lambda_language_tokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KW_CHARS       = 6;
  localparam int HOLDOFF_CYCLES = 200;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic clk;
  logic rst_n;

  llt_chan_if #(.payload_t(llt_pkg::in_item_t))  in_chan  ();
  llt_chan_if #(.payload_t(llt_pkg::out_item_t)) out_chan ();

  lambda_language_tokenizer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Keyword spellings in token-kind order, and the punctuation marks likewise.
  string kw_list [24] = '{
    "if", "then", "else", "true", "false", "pred", "succ", "iszero",
    "nil", "cons", "isnil", "head", "tail", "unit", "lambda", "let",
    "in", "letrec", "type", "as", "Bool", "Nat", "List", "Unit"
  };
  string punct_list = ".,:;=_(){}[]";

  // Character beats waiting for the driver, and token beats still owed.
  llt_pkg::in_item_t  chars_pending [$];
  llt_pkg::out_item_t tokens_due [$];
  logic [7:0]         text_buf [$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  bit in_beat_taken  = 1'b0;

  // Shadow lexer state.
  llt_pkg::lex_mode_t lx_mode;
  logic [15:0] lx_pos;
  logic [15:0] lx_start;
  logic [30:0] lx_acc;
  logic [7:0]  lx_word [KW_CHARS];
  logic [2:0]  lx_wlen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow lexer
  // --------------------------------------------------------------------------
  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic void owe_token(llt_pkg::kind_t k, logic [15:0] s, logic [15:0] e,
                                    logic [30:0] v, logic err, logic last);
    llt_pkg::out_item_t t;
    t.kind         = k;
    t.start_pos    = s;
    t.end_pos      = e;
    t.number_value = v;
    t.lex_error    = err;
    t.last_result  = last;
    tokens_due.insert(tokens_due.size(), t);
  endfunction

  // Words longer than the keyword buffer are always plain identifiers.
  function automatic llt_pkg::kind_t word_kind();
    bit hit;
    if (lx_wlen > KW_CHARS) return llt_pkg::KIND_ID;
    for (int k = 0; k < 24; k++) begin
      hit = (kw_list[k].len() == lx_wlen);
      for (int i = 0; i < lx_wlen && hit; i++)
        if (kw_list[k][i] != lx_word[i]) hit = 1'b0;
      if (hit) return llt_pkg::kind_t'(llt_pkg::KIND_KW0 + k);
    end
    return llt_pkg::KIND_ID;
  endfunction

  function automatic void restart_text();
    lx_mode  = llt_pkg::MODE_IDLE;
    lx_pos   = '0;
    lx_start = '0;
    lx_acc   = '0;
    lx_wlen  = '0;
  endfunction

  // Emit the pending number or word, closing it at offset e.
  function automatic void close_token(logic [15:0] e);
    if (lx_mode == llt_pkg::MODE_NUM)
      owe_token(llt_pkg::KIND_NUM, lx_start, e, lx_acc, 1'b0, 1'b0);
    else if (lx_mode == llt_pkg::MODE_WORD)
      owe_token(word_kind(), lx_start, e, '0, 1'b0, 1'b0);
    lx_mode = llt_pkg::MODE_IDLE;
  endfunction

  // Advance the shadow lexer by one character and owe the tokens it yields.
  function automatic void lex_char(llt_pkg::in_item_t it);
    logic [7:0]  c;
    logic        fin;
    logic [15:0] here;
    logic [15:0] after;
    logic [34:0] wide;
    bit          taken;
    int          pi;
    c     = it.ch;
    fin   = it.final_char;
    here  = lx_pos;
    after = lx_pos + 16'd1;
    taken = 1'b0;
    pi    = -1;

    // Swallow everything after an error up to the end of the text.
    if (lx_mode == llt_pkg::MODE_ERR) begin
      if (fin) restart_text();
      return;
    end

    case (lx_mode)
      llt_pkg::MODE_MINUS: begin
        if (c == llt_pkg::CH_GT) begin
          owe_token(llt_pkg::KIND_ARROW, lx_start, after, '0, 1'b0, 1'b0);
          lx_mode = llt_pkg::MODE_IDLE;
          taken   = 1'b1;
        end else begin
          // Lone minus: report it and drop the character after it.
          owe_token(llt_pkg::KIND_END, lx_start, lx_start + 16'd1, '0, 1'b1, 1'b1);
          lx_mode = llt_pkg::MODE_ERR;
          if (fin) restart_text();
          else lx_pos = after;
          return;
        end
      end
      llt_pkg::MODE_NUM: begin
        if (is_digit(c)) begin
          wide   = 35'(lx_acc) * 35'd10 + 35'(c - "0");
          lx_acc = (wide > 35'(llt_pkg::NUM_MAX)) ? llt_pkg::NUM_MAX : wide[30:0];
          taken  = 1'b1;
        end else begin
          close_token(here);
        end
      end
      llt_pkg::MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || c == llt_pkg::CH_USCORE ||
            c == llt_pkg::CH_QUOTE) begin
          if (lx_wlen < KW_CHARS) lx_word[lx_wlen] = c;
          if (lx_wlen <= KW_CHARS) lx_wlen++;
          taken = 1'b1;
        end else begin
          close_token(here);
        end
      end
      default: ;
    endcase

    if (!taken) begin
      for (int i = 0; i < 12; i++)
        if (punct_list[i] == c) pi = i;
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
        // blanks only separate tokens
      end else if (pi >= 0) begin
        owe_token(llt_pkg::kind_t'(llt_pkg::KIND_PUNCT0 + pi), here, after, '0, 1'b0, 1'b0);
      end else if (c == llt_pkg::CH_MINUS) begin
        lx_mode  = llt_pkg::MODE_MINUS;
        lx_start = here;
      end else if (is_digit(c)) begin
        lx_mode  = llt_pkg::MODE_NUM;
        lx_start = here;
        lx_acc   = 31'(c - "0");
      end else if (is_alpha(c)) begin
        lx_mode    = llt_pkg::MODE_WORD;
        lx_start   = here;
        lx_word[0] = c;
        lx_wlen    = 3'd1;
      end else begin
        // Illegal character: any pending token went out first.
        owe_token(llt_pkg::KIND_END, here, after, '0, 1'b1, 1'b1);
        lx_mode = llt_pkg::MODE_ERR;
        if (fin) restart_text();
        else lx_pos = after;
        return;
      end
    end

    lx_pos = after;
    if (fin) begin
      // A trailing minus replaces the end marker with the lone-minus error.
      if (lx_mode == llt_pkg::MODE_MINUS) begin
        owe_token(llt_pkg::KIND_END, lx_start, lx_start + 16'd1, '0, 1'b1, 1'b1);
      end else begin
        close_token(after);
        owe_token(llt_pkg::KIND_END, after, after, '0, 1'b0, 1'b1);
      end
      restart_text();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Text generation
  // --------------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.insert(text_buf.size(), s[i]);
  endfunction

  // Hand the buffered text to the driver, last-flag on its final character.
  function automatic void queue_text();
    llt_pkg::in_item_t it;
    for (int i = 0; i < text_buf.size(); i++) begin
      it.ch         = text_buf[i];
      it.final_char = (i == text_buf.size() - 1);
      chars_pending.insert(chars_pending.size(), it);
    end
    text_buf.delete();
  endfunction

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 1)) return 8'("a" + $urandom_range(0, 25));
    return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 5))
      0, 1, 2: return pick_letter();
      3:       return 8'("0" + $urandom_range(0, 9));
      4:       return llt_pkg::CH_USCORE;
      default: return llt_pkg::CH_QUOTE;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // Mostly well-formed tokens; now and then an illegal byte or a stray minus.
  function automatic void add_token();
    string kw;
    int    n;
    if ($urandom_range(0, 24) == 0) begin
      case ($urandom_range(0, 2))
        0: add_char(8'($urandom_range(0, 255)));
        1: add_char(8'($urandom_range(128, 255)));
        default: begin
          add_char(llt_pkg::CH_MINUS);
          add_char(8'($urandom_range(0, 255)));
        end
      endcase
      return;
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        // keyword, sometimes stretched so it no longer matches
        add_str(kw_list[$urandom_range(0, 23)]);
        if ($urandom_range(0, 3) == 0) add_char(pick_word_char());
      end
      2, 3: begin
        add_char(pick_letter());
        n = $urandom_range(0, 9);
        repeat (n) add_char(pick_word_char());
      end
      4, 5: begin
        // short numbers mostly, long ones to hit saturation
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
        repeat (n) add_char(8'("0" + $urandom_range(0, 9)));
      end
      6: add_char(punct_list[$urandom_range(0, 11)]);
      7: add_str("->");
      8: begin
        // keyword prefix: a near miss
        kw = kw_list[$urandom_range(0, 23)];
        add_str(kw.substr(0, kw.len() - 2));
      end
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) add_char(pick_blank());
      end
    endcase
  endfunction

  // Queue random texts until roughly n_chars beats have been added.
  function automatic void queue_random(int n_chars);
    int target;
    int n_tok;
    target = chars_pending.size() + n_chars;
    while (chars_pending.size() < target) begin
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) add_token();
      if ($urandom_range(0, 7) == 0) add_char(llt_pkg::CH_MINUS);
      queue_text();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer a new character beat at the falling edge once the last
  // one has gone, idling at the current rate.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!in_chan.valid || in_beat_taken) begin
      if (rst_n && chars_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_chan.data  <= chars_pending.pop_front();
        in_chan.valid <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request to back up the
  // lexer until it refuses input.
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_left   = HOLDOFF_CYCLES;
      hold_served = hold_asked;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: forecast on every accepted character beat, check every token
  // beat against the oldest forecast.
  // --------------------------------------------------------------------------
  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    llt_pkg::out_item_t want;
    in_beat_taken = rst_n && in_chan.valid && in_chan.ready;
    if (in_beat_taken) lex_char(in_chan.data);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (tokens_due.size() == 0) begin
        $error("token beat with nothing owed: kind %0d at %0d",
               out_chan.data.kind, out_chan.data.start_pos);
        mismatches++;
      end else begin
        want = tokens_due.pop_front();
        check_field("kind",         32'(want.kind),         32'(out_chan.data.kind));
        check_field("start_pos",    32'(want.start_pos),    32'(out_chan.data.start_pos));
        check_field("end_pos",      32'(want.end_pos),      32'(out_chan.data.end_pos));
        check_field("number_value", 32'(want.number_value), 32'(out_chan.data.number_value));
        check_field("lex_error",    32'(want.lex_error),    32'(out_chan.data.lex_error));
        check_field("last_result",  32'(want.last_result),  32'(out_chan.data.last_result));
      end
    end
  end

  // Hold here until the driver has handed over every queued beat.
  task automatic wait_sent();
    while (chars_pending.size() != 0 || in_chan.valid) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int send_pct [4];
    int recv_pct [4];
    int drain_cycles;

    send_pct = '{0, 48, 0, 18};
    recv_pct = '{0, 0, 48, 18};

    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    out_chan.ready = 1'b0;
    rst_n          = 1'b0;
    restart_text();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: six-letter keyword, identifier with quote and underscore,
    // arrow, saturating number, punctuation closing on the last flag.
    add_str("iszero");
    add_char(CH_TAB);
    add_str("b_'->2147483648(");
    queue_text();
    // lone minus, then a dropped character carrying the last flag
    add_str("-x");
    queue_text();
    // pending word flushed ahead of an illegal top-bit byte on the last flag
    add_str("a");
    add_char(8'hFF);
    queue_text();
    // minus on the last flag
    add_char(llt_pkg::CH_MINUS);
    queue_text();
    // NUL is illegal too
    add_char(8'h00);
    queue_text();
    // error mid-text: the rest is ignored up to the last flag
    add_str("x#yz 12");
    queue_text();
    wait_sent();

    // Random texts under each idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      queue_random(40);
      wait_sent();
    end

    // Back-pressure: hold the receiver off while the sender keeps offering.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    queue_random(30);
    wait_sent();

    // Drain the owed tokens, then keep watching for stray beats.
    drain_cycles = 0;
    while (tokens_due.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (tokens_due.size() != 0) begin
      $error("%0d token beats never arrived", tokens_due.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
